### hdl/ibb_pkg.sv
// ---------------------------------------------------------------------------
// ibb_pkg
// Shared types, constants and the reciprocal table for the 3x3 box blur.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ibb_pkg;

    // default frame limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0] RESET_IMAGE_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RESET_IMAGE_HEIGHT = 11'd480;

    // pixel and arithmetic widths
    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int NUM_TAPS  = 9;
    localparam int SUM_W     = 12;
    localparam int CNT_W     = 4;
    localparam int RECIP_W   = 19;
    localparam int DIV_SHIFT = 18;
    localparam int PROD_W    = SUM_W + RECIP_W;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    // which neighbors lie inside the frame
    typedef struct packed {
        logic left;
        logic right;
        logic up;
        logic down;
    } nbr_mask_t;

    // 3x3 neighborhood: top row blurred, left blurred, the rest original
    typedef struct packed {
        pixel_t up_left;
        pixel_t up;
        pixel_t up_right;
        pixel_t left;
        pixel_t self_pix;
        pixel_t right;
        pixel_t down_left;
        pixel_t down;
        pixel_t down_right;
    } window_t;

    // ceil(2^18 / n): exact floor division for sums below 2^12
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        case (cnt)
            4'd1:    m = 19'd262144;
            4'd2:    m = 19'd131072;
            4'd3:    m = 19'd87382;
            4'd4:    m = 19'd65536;
            4'd5:    m = 19'd52429;
            4'd6:    m = 19'd43691;
            4'd7:    m = 19'd37450;
            4'd8:    m = 19'd32768;
            4'd9:    m = 19'd29128;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

### hdl/inplace_box_blur_3x3.sv
// ---------------------------------------------------------------------------
// inplace_box_blur_3x3
// Streaming 3x3 box blur with in-place semantics over RGB raster pixels.
// ---------------------------------------------------------------------------
// Each output pixel is the truncated per-channel mean of its 3x3 neighbors
// that lie inside the frame; the neighbors above and to the left contribute
// their already blurred values, the others their original values. Outputs
// trail inputs by image_width+1 items, so a frame is closed with
// image_width+1 padding items; end_of_frame marks the last output pixel and
// the next item starts a new frame. Padding sent while pixels are still
// expected is dropped; pixels sent during the flush count as padding. A
// register write restarts the frame; 0 acts as 1 and values above the
// maximum saturate. An item that completes an output pixel passes through
// accept, two reads on the original ring and blurred line memories (one
// read port each), sum, multiply and write-back, with in_stall held high;
// write-back waits while the output register is full and stalled. The
// line memories are not cleared after reset; the ring is only read at
// entries already written in the current frame, and first-row blurred reads are masked out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module inplace_box_blur_3x3
#(
    parameter int MAX_WIDTH  = ibb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ibb_pkg::DEF_MAX_HEIGHT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ibb_pkg::CH_W-1:0]      red_in,
    input  logic [ibb_pkg::CH_W-1:0]      green_in,
    input  logic [ibb_pkg::CH_W-1:0]      blue_in,
    input  logic                          is_padding,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ibb_pkg::CH_W-1:0]      red_out,
    output logic [ibb_pkg::CH_W-1:0]      green_out,
    output logic [ibb_pkg::CH_W-1:0]      blue_out,
    output logic                          end_of_frame,
    input  logic                          cfg_we,
    input  logic [ibb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ibb_pkg::CFG_W-1:0]     cfg_data
);

    import ibb_pkg::*;

    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int HW         = $clog2(MAX_HEIGHT + 1);
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int RING_DEPTH = MAX_WIDTH + 2;
    localparam int RAW        = $clog2(RING_DEPTH);
    localparam int LW         = $clog2(MAX_WIDTH + 2);
    localparam int CWW        = (WW > CFG_W) ? WW : CFG_W;
    localparam int CHW        = (HW > CFG_W) ? HW : CFG_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD0  = 6'b000010,
        S_RD1  = 6'b000100,
        S_SUM  = 6'b001000,
        S_MUL  = 6'b010000,
        S_WB   = 6'b100000
    } state_t;

    // size registers clamp to 1..max
    function automatic logic [WW-1:0] clamp_width(input logic [CFG_W-1:0] v);
        logic [CWW-1:0] ext;
        ext = CWW'(v);
        if (v == '0)
            return WW'(1);
        else if (ext > CWW'(MAX_WIDTH))
            return WW'(MAX_WIDTH);
        else
            return WW'(ext);
    endfunction

    function automatic logic [HW-1:0] clamp_height(input logic [CFG_W-1:0] v);
        logic [CHW-1:0] ext;
        ext = CHW'(v);
        if (v == '0)
            return HW'(1);
        else if (ext > CHW'(MAX_HEIGHT))
            return HW'(MAX_HEIGHT);
        else
            return HW'(ext);
    endfunction

    // ring entry back_cnt items behind ptr
    function automatic logic [RAW-1:0] ring_back(input logic [RAW-1:0] ptr,
                                                 input logic [RAW:0]   back_cnt);
        logic [RAW:0] p;
        p = (RAW+1)'(ptr);
        if (p >= back_cnt)
            return RAW'(p - back_cnt);
        else
            return RAW'(p + (RAW+1)'(RING_DEPTH) - back_cnt);
    endfunction

    state_t state_reg, state_next;

    logic [WW-1:0]  width_reg, width_next;
    logic [HW-1:0]  height_reg, height_next;
    logic [RAW-1:0] wp_reg, wp_next;
    logic [LW-1:0]  lead_reg, lead_next;
    logic [XW-1:0]  in_x_reg, in_x_next;
    logic [YW-1:0]  in_y_reg, in_y_next;
    logic           all_in_reg, all_in_next;
    logic [XW-1:0]  col_reg, col_next;
    logic [YW-1:0]  row_reg, row_next;
    logic           out_valid_reg, out_valid_next;

    pixel_t prev1_reg;
    pixel_t prev2_reg;
    pixel_t dl_reg;
    pixel_t dn_reg;
    pixel_t dr_reg;
    pixel_t self_reg;
    pixel_t up_reg;
    pixel_t ul_reg;
    pixel_t left_reg;
    pixel_t out_pix_reg;
    logic   out_eof_reg;

    logic       accept;
    logic       take;
    logic       emit;
    logic       wb_fire;
    logic       frame_done;
    logic       at_last_col;
    logic       at_last_row;
    logic       in_last_col;
    logic       in_last_row;
    pixel_t     item_pix;
    nbr_mask_t  mask;
    window_t    window;
    pixel_t     mean_result;

    logic [RAW:0]   self_dist;
    logic [RAW-1:0] ring_waddr;
    logic [RAW-1:0] ring_raddr;
    pixel_t         ring_rdata;
    logic [XW-1:0]  blur_raddr;
    pixel_t         blur_rdata;

    // input handshake
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign take     = accept && (all_in_reg || !is_padding);
    assign emit     = (lead_reg >= (LW'(width_reg) + LW'(1)));
    assign item_pix = all_in_reg ? pixel_t'('0) : pixel_t'({red_in, green_in, blue_in});

    // position flags
    assign at_last_col = (WW'(col_reg) == (width_reg - WW'(1)));
    assign at_last_row = (HW'(row_reg) == (height_reg - HW'(1)));
    assign in_last_col = (WW'(in_x_reg) == (width_reg - WW'(1)));
    assign in_last_row = (HW'(in_y_reg) == (height_reg - HW'(1)));
    assign frame_done  = at_last_col && at_last_row;

    assign mask.left  = (col_reg != '0);
    assign mask.right = !at_last_col;
    assign mask.up    = (row_reg != '0);
    assign mask.down  = !at_last_row;

    // write-back fires when the output register is free
    assign wb_fire = (state_reg == S_WB) && (!out_valid_reg || !out_stall);

    // ring addressing
    assign wp_next    = (wp_reg == RAW'(RING_DEPTH - 1)) ? '0 : (wp_reg + RAW'(1));
    assign ring_waddr = wp_next;
    assign self_dist  = (RAW+1)'(width_reg) + (RAW+1)'(1);
    assign ring_raddr = (state_reg == S_RD0) ? ring_back(wp_reg, self_dist)
                                             : ring_back(wp_reg, (RAW+1)'(width_reg));

    // blurred line addressing: own column, then the one to the right
    assign blur_raddr = ((state_reg == S_RD1) && mask.right) ? (col_reg + XW'(1)) : col_reg;

    // original pixel ring
    ibb_ram
    #(
        .WIDTH (PIX_W),
        .DEPTH (RING_DEPTH)
    )
    u_ring
    (
        .clk   (clk),
        .we    (take),
        .waddr (ring_waddr),
        .wdata (item_pix),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    // blurred line per column
    ibb_ram
    #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    )
    u_blur
    (
        .clk   (clk),
        .we    (wb_fire),
        .waddr (col_reg),
        .wdata (mean_result),
        .raddr (blur_raddr),
        .rdata (blur_rdata)
    );

    // neighborhood assembly; right and up-right arrive from the memories
    assign window.up_left    = ul_reg;
    assign window.up         = up_reg;
    assign window.up_right   = blur_rdata;
    assign window.left       = left_reg;
    assign window.self_pix   = self_reg;
    assign window.right      = ring_rdata;
    assign window.down_left  = dl_reg;
    assign window.down       = dn_reg;
    assign window.down_right = dr_reg;

    ibb_mean u_mean
    (
        .clk    (clk),
        .start  (state_reg == S_SUM),
        .window (window),
        .mask   (mask),
        .result (mean_result)
    );

    // sequencer and counters
    always_comb
    begin
        state_next     = state_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        lead_next      = lead_reg;
        in_x_next      = in_x_reg;
        in_y_next      = in_y_reg;
        all_in_next    = all_in_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (!all_in_reg)
                    begin
                        if (in_last_col)
                        begin
                            in_x_next = '0;
                            if (in_last_row)
                            begin
                                in_y_next   = '0;
                                all_in_next = 1'b1;
                            end
                            else
                            begin
                                in_y_next = in_y_reg + YW'(1);
                            end
                        end
                        else
                        begin
                            in_x_next = in_x_reg + XW'(1);
                        end
                    end
                    if (emit)
                    begin
                        state_next = S_RD0;
                    end
                    else
                    begin
                        lead_next = lead_reg + LW'(1);
                    end
                end
            end
            S_RD0:
            begin
                state_next = S_RD1;
            end
            S_RD1:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                if (wb_fire)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    if (frame_done)
                    begin
                        col_next    = '0;
                        row_next    = '0;
                        lead_next   = '0;
                        in_x_next   = '0;
                        in_y_next   = '0;
                        all_in_next = 1'b0;
                    end
                    else if (at_last_col)
                    begin
                        col_next = '0;
                        row_next = row_reg + YW'(1);
                    end
                    else
                    begin
                        col_next = col_reg + XW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register write restarts the frame
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_next  = clamp_width(cfg_data);
                REG_IMAGE_HEIGHT: height_next = clamp_height(cfg_data);
                default:          width_next  = width_reg;
            endcase
            lead_next   = '0;
            in_x_next   = '0;
            in_y_next   = '0;
            all_in_next = 1'b0;
            col_next    = '0;
            row_next    = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= clamp_width(RESET_IMAGE_WIDTH);
            height_reg    <= clamp_height(RESET_IMAGE_HEIGHT);
            wp_reg        <= '0;
            lead_reg      <= '0;
            in_x_reg      <= '0;
            in_y_reg      <= '0;
            all_in_reg    <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            if (take)
            begin
                wp_reg <= wp_next;
            end
            lead_reg      <= lead_next;
            in_x_reg      <= in_x_next;
            in_y_reg      <= in_y_next;
            all_in_reg    <= all_in_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // window and output data
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            prev1_reg <= item_pix;
            prev2_reg <= prev1_reg;
            dl_reg    <= prev2_reg;
            dn_reg    <= prev1_reg;
            dr_reg    <= item_pix;
        end
        if (state_reg == S_RD1)
        begin
            self_reg <= ring_rdata;
            up_reg   <= blur_rdata;
        end
        if (wb_fire)
        begin
            ul_reg      <= up_reg;
            left_reg    <= mean_result;
            out_pix_reg <= mean_result;
            out_eof_reg <= frame_done;
        end
    end

    // output ports
    assign out_valid    = out_valid_reg;
    assign red_out      = out_pix_reg.red;
    assign green_out    = out_pix_reg.green;
    assign blue_out     = out_pix_reg.blue;
    assign end_of_frame = out_eof_reg;

endmodule

`default_nettype wire

### hdl/ibb_ram.sv
// ---------------------------------------------------------------------------
// ibb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ibb_ram
#(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/ibb_mean.sv
// ---------------------------------------------------------------------------
// ibb_mean
// Masked 3x3 channel sums, then division by the tap count through a
// reciprocal multiply. Sums register on start, products in the cycle after.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ibb_mean
(
    input  logic              clk,
    input  logic              start,
    input  ibb_pkg::window_t  window,
    input  ibb_pkg::nbr_mask_t mask,
    output ibb_pkg::pixel_t   result
);

    import ibb_pkg::*;

    pixel_t [NUM_TAPS-1:0] terms;
    logic [NUM_TAPS-1:0]   term_en;

    logic [SUM_W-1:0] red_sum;
    logic [SUM_W-1:0] green_sum;
    logic [SUM_W-1:0] blue_sum;
    logic [CNT_W-1:0] term_cnt;

    logic [SUM_W-1:0] red_sum_reg;
    logic [SUM_W-1:0] green_sum_reg;
    logic [SUM_W-1:0] blue_sum_reg;
    logic [CNT_W-1:0] term_cnt_reg;

    logic [RECIP_W-1:0] recip_val;

    logic [PROD_W-1:0] red_prod_reg;
    logic [PROD_W-1:0] green_prod_reg;
    logic [PROD_W-1:0] blue_prod_reg;

    // taps and their enables
    assign terms = {window.up_left, window.up, window.up_right, window.left,
                    window.self_pix, window.right, window.down_left, window.down,
                    window.down_right};
    assign term_en = {mask.up & mask.left, mask.up, mask.up & mask.right, mask.left,
                      1'b1, mask.right, mask.down & mask.left, mask.down,
                      mask.down & mask.right};

    // channel sums over the taps inside the frame
    always_comb
    begin
        red_sum   = '0;
        green_sum = '0;
        blue_sum  = '0;
        term_cnt  = '0;
        for (int i = 0; i < NUM_TAPS; i++)
        begin
            if (term_en[i])
            begin
                red_sum   = red_sum + SUM_W'(terms[i].red);
                green_sum = green_sum + SUM_W'(terms[i].green);
                blue_sum  = blue_sum + SUM_W'(terms[i].blue);
                term_cnt  = term_cnt + CNT_W'(1);
            end
        end
    end

    // sum stage
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            red_sum_reg   <= red_sum;
            green_sum_reg <= green_sum;
            blue_sum_reg  <= blue_sum;
            term_cnt_reg  <= term_cnt;
        end
    end

    assign recip_val = recip(term_cnt_reg);

    // reciprocal multiply stage
    always_ff @(posedge clk)
    begin
        red_prod_reg   <= PROD_W'(red_sum_reg) * PROD_W'(recip_val);
        green_prod_reg <= PROD_W'(green_sum_reg) * PROD_W'(recip_val);
        blue_prod_reg  <= PROD_W'(blue_sum_reg) * PROD_W'(recip_val);
    end

    // quotient
    assign result.red   = red_prod_reg[DIV_SHIFT +: CH_W];
    assign result.green = green_prod_reg[DIV_SHIFT +: CH_W];
    assign result.blue  = blue_prod_reg[DIV_SHIFT +: CH_W];

endmodule

`default_nettype wire
